@@ design/ipsl_pkg.sv @@
// shared constants and types for the incremental pi speed loop
`default_nettype none
package ipsl_pkg;

    // default number of fraction bits in error, target and drive accumulator
    localparam int FRAC_BITS_DEF = 8;

    localparam int GAIN_FRAC  = 8;
    localparam int SPEED_FRAC = 8;
    localparam int MS_PER_SECOND = 1000;

    // target conversion divides by ms per second with the speed fraction removed
    localparam int TARGET_DIV = MS_PER_SECOND << SPEED_FRAC;
    localparam int DIV_RW     = 18;

    // |speed| (17 bits) * encoder counts per revolution (16 bits) * period (8 bits)
    localparam int TGT_PROD_W = 41;

    // serial multiplier datapath width, holds the largest gain product sum
    localparam int MUL_W          = 52;
    localparam int MUL_BITS       = 16;
    localparam int MUL_SHORT_BITS = 8;

    localparam int PULSE_SAT    = 32767;
    localparam int PERIOD_RESET = 10;
    localparam int LIMIT_RESET  = 32767;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_INTEGRAL  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_SPEED   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COUNTS_PER_REV = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_TICKS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT    = 3'd5;

    typedef struct packed {
        logic start;
        logic clear;
        logic short_op;
    } mul_ctl_t;

endpackage
`default_nettype wire

@@ design/ipsl_mul.sv @@
// bit-serial shift-add multiplier, one multiplier bit per cycle, accumulating
`default_nettype none
module ipsl_mul
    import ipsl_pkg::*;
#(
    parameter int PW = MUL_W
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire mul_ctl_t             ctl,
    input  wire logic signed [PW-1:0] a_in,
    input  wire logic [MUL_BITS-1:0]  b_in,
    output logic                      done,
    output logic signed [PW-1:0]      prod
);

    localparam int CW = $clog2(MUL_BITS + 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic signed [PW-1:0] a_reg, a_next;
    logic [MUL_BITS-1:0]  b_reg, b_next;
    logic signed [PW-1:0] acc_reg, acc_next;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        if (ctl.start) begin
            busy_next = 1'b1;
            cnt_next  = ctl.short_op ? CW'(MUL_SHORT_BITS) : CW'(MUL_BITS);
            a_next    = a_in;
            b_next    = b_in;
            if (ctl.clear) begin
                acc_next = '0;
            end
        end else if (busy_reg) begin
            if (b_reg[0]) begin
                acc_next = acc_reg + a_reg;
            end
            a_next   = a_reg <<< 1;
            b_next   = b_reg >> 1;
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule
`default_nettype wire

@@ design/ipsl_div.sv @@
// restoring divider by the target conversion constant, one quotient bit per cycle
`default_nettype none
module ipsl_div
    import ipsl_pkg::*;
#(
    parameter int DW = TGT_PROD_W + FRAC_BITS_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start,
    input  wire logic [DW-1:0] dividend,
    output logic               done,
    output logic [DW-1:0]      quotient
);

    localparam int CW = $clog2(DW + 1);
    localparam logic [DIV_RW:0] DIVISOR = (DIV_RW + 1)'(TARGET_DIV);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [DW-1:0]     dvd_reg, dvd_next;
    logic [DIV_RW-1:0] rem_reg, rem_next;
    logic [DIV_RW:0]   trial;
    logic              q_bit;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        trial     = {rem_reg, dvd_reg[DW-1]};
        q_bit     = trial >= DIVISOR;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CW'(DW);
            dvd_next  = dividend;
            rem_next  = '0;
        end else if (busy_reg) begin
            // quotient bits shift in at the bottom as dividend bits leave the top
            rem_next = q_bit ? DIV_RW'(trial - DIVISOR) : trial[DIV_RW-1:0];
            dvd_next = {dvd_reg[DW-2:0], q_bit};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule
`default_nettype wire

@@ design/incremental_pi_speed_loop.sv @@
// Incremental PI speed loop: one input item per millisecond tick or brake command.
// Input channel s_*: s_mode (0 tick, 1 brake) and s_encoder_pulses for that tick.
// Result channel m_*: m_drive, m_updated, m_braking, one result per input item.
// Configuration: cfg_wr_en with cfg_index / cfg_data writes a register; the user must write
// only while no item is in flight, as the block itself does not enforce this.
// A tick that runs no control step, and a brake, give their result in the cycle after
// acceptance. A control step runs the target products, the divide, the error and the
// gain products in turn; a target forced to zero skips straight to the error.
// It uses the shared bit-serial multiplier (one multiplier bit per cycle, run four times,
// or twice for a zero target) and the restoring divider (one quotient bit per cycle).
// One item is worked on at a time; s_ready is high when idle and the output register
// is empty or being taken, so the next item can be accepted in the cycle its
// predecessor's result leaves.
// If the receiver stalls, the result stays in the output register and a following
// item waits at s_ready.
// Reset (aresetn low, synchronous) clears the pulse sum, tick counter, drive
// accumulator, last error and brake hold, and loads register defaults
// (period 10, drive limit 32767, the rest zero).
`default_nettype none
module incremental_pi_speed_loop
    import ipsl_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  s_mode,
    input  wire logic signed [10:0]    s_encoder_pulses,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic signed [15:0]         m_drive,
    output logic                       m_updated,
    output logic                       m_braking,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int DW   = TGT_PROD_W + FRAC_BITS;
    localparam int ERRW = DW + 2;
    localparam int ACW  = 16 + FRAC_BITS;
    localparam int SUMW = MUL_W - GAIN_FRAC + 1;

    localparam logic signed [ERRW-1:0] ERR_MAX = (ERRW'(1) << 31) - ERRW'(1);
    localparam logic signed [ERRW-1:0] ERR_MIN = ERRW'(0) - (ERRW'(1) << 31);
    localparam logic signed [16:0]     SUM_MAX = 17'(PULSE_SAT);
    localparam logic signed [16:0]     SUM_MIN = 17'(0) - 17'(PULSE_SAT);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_TGT1 = 7'b0000010,
        S_TGT2 = 7'b0000100,
        S_DIV  = 7'b0001000,
        S_ERR  = 7'b0010000,
        S_PMUL = 7'b0100000,
        S_IMUL = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [15:0]        kp_reg, kp_next;
    logic [15:0]        ki_reg, ki_next;
    logic signed [15:0] speed_reg, speed_next;
    logic [15:0]        ppr_reg, ppr_next;
    logic [7:0]         period_reg, period_next;
    logic [14:0]        limit_reg, limit_next;

    logic signed [15:0]     pulse_sum_reg, pulse_sum_next;
    logic [7:0]             ticks_reg, ticks_next;
    logic signed [ACW-1:0]  accum_reg, accum_next;
    logic signed [31:0]     last_err_reg, last_err_next;
    logic                   held_reg, held_next;
    logic signed [31:0]     err_reg, err_next;
    logic                   zero_tgt_reg, zero_tgt_next;

    logic               m_valid_reg, m_valid_next;
    logic signed [15:0] drive_reg, drive_next;
    logic               updated_reg, updated_next;
    logic               braking_reg, braking_next;

    logic                    accept;
    logic signed [16:0]      sum_wide;
    logic signed [15:0]      sum_sat;
    logic [7:0]              ticks_inc;
    logic                    step_now;
    logic signed [16:0]      sp_ext;
    logic [16:0]             sp_mag;
    logic                    zero_tgt_now;
    logic signed [ERRW-1:0]  tq_s;
    logic signed [ERRW-1:0]  t_s;
    logic signed [ERRW-1:0]  ps;
    logic signed [ERRW-1:0]  e_wide;
    logic signed [31:0]      err_now;
    logic signed [32:0]      ediff;
    logic signed [SUMW-1:0]  delta;
    logic signed [SUMW-1:0]  acc_sum;
    logic signed [SUMW-1:0]  lim_s;
    logic signed [SUMW-1:0]  acc_clamp;

    mul_ctl_t                mul_ctl;
    logic signed [MUL_W-1:0] mul_a;
    logic [MUL_BITS-1:0]     mul_b;
    logic                    mul_done;
    logic signed [MUL_W-1:0] mul_prod;
    logic                    div_start;
    logic [DW-1:0]           div_dividend;
    logic                    div_done;
    logic [DW-1:0]           div_q;

    // drive is the accumulator truncated toward zero
    function automatic logic signed [15:0] drive_of(input logic signed [ACW-1:0] a);
        logic signed [ACW-1:0] fl;
        logic                  rnd;
        fl  = a >>> FRAC_BITS;
        rnd = a[ACW-1] && (a[FRAC_BITS-1:0] != '0);
        return 16'(fl) + 16'(rnd);
    endfunction

    ipsl_mul #(
        .PW (MUL_W)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (mul_ctl),
        .a_in    (mul_a),
        .b_in    (mul_b),
        .done    (mul_done),
        .prod    (mul_prod)
    );

    ipsl_div #(
        .DW (DW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .done     (div_done),
        .quotient (div_q)
    );

    assign s_ready = (state_reg == S_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;

    always_comb begin
        sum_wide = 17'(pulse_sum_reg) + 17'(s_encoder_pulses);
        if (sum_wide > SUM_MAX) begin
            sum_sat = 16'(SUM_MAX);
        end else if (sum_wide < SUM_MIN) begin
            sum_sat = 16'(SUM_MIN);
        end else begin
            sum_sat = 16'(sum_wide);
        end
        ticks_inc    = (ticks_reg == 8'hFF) ? ticks_reg : ticks_reg + 8'd1;
        step_now     = ticks_inc >= period_reg;
        sp_ext       = 17'(speed_reg);
        sp_mag       = speed_reg[15] ? 17'(-sp_ext) : 17'(sp_ext);
        zero_tgt_now = held_reg || (ppr_reg == '0) || (period_reg == '0);

        // error against the target, saturated to 32 bits
        tq_s   = zero_tgt_reg ? '0 : ERRW'(div_q);
        t_s    = speed_reg[15] ? -tq_s : tq_s;
        ps     = ERRW'(pulse_sum_reg) <<< FRAC_BITS;
        e_wide = t_s - ps;
        if (e_wide > ERR_MAX) begin
            err_now = 32'(ERR_MAX);
        end else if (e_wide < ERR_MIN) begin
            err_now = 32'(ERR_MIN);
        end else begin
            err_now = 32'(e_wide);
        end
        ediff = 33'(err_now) - 33'(last_err_reg);

        // arithmetic shift of the gain sum is floor rounding
        delta   = SUMW'(mul_prod >>> GAIN_FRAC);
        acc_sum = SUMW'(accum_reg) + delta;
        lim_s   = SUMW'({1'b0, limit_reg, {FRAC_BITS{1'b0}}});
        if (acc_sum > lim_s) begin
            acc_clamp = lim_s;
        end else if (acc_sum < -lim_s) begin
            acc_clamp = -lim_s;
        end else begin
            acc_clamp = acc_sum;
        end
    end

    always_comb begin
        state_next     = state_reg;
        kp_next        = kp_reg;
        ki_next        = ki_reg;
        speed_next     = speed_reg;
        ppr_next       = ppr_reg;
        period_next    = period_reg;
        limit_next     = limit_reg;
        pulse_sum_next = pulse_sum_reg;
        ticks_next     = ticks_reg;
        accum_next     = accum_reg;
        last_err_next  = last_err_reg;
        held_next      = held_reg;
        err_next       = err_reg;
        zero_tgt_next  = zero_tgt_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        drive_next     = drive_reg;
        updated_next   = updated_reg;
        braking_next   = braking_reg;
        mul_ctl        = '0;
        mul_a          = '0;
        mul_b          = '0;
        div_start      = 1'b0;
        div_dividend   = {mul_prod[TGT_PROD_W-1:0], {FRAC_BITS{1'b0}}};

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (s_mode) begin
                        accum_next    = '0;
                        last_err_next = '0;
                        held_next     = 1'b1;
                        m_valid_next  = 1'b1;
                        drive_next    = '0;
                        updated_next  = 1'b0;
                        braking_next  = 1'b1;
                    end else begin
                        pulse_sum_next = sum_sat;
                        ticks_next     = ticks_inc;
                        if (step_now) begin
                            zero_tgt_next = zero_tgt_now;
                            if (zero_tgt_now) begin
                                state_next = S_ERR;
                            end else begin
                                mul_ctl.start = 1'b1;
                                mul_ctl.clear = 1'b1;
                                mul_a         = MUL_W'(sp_mag);
                                mul_b         = ppr_reg;
                                state_next    = S_TGT1;
                            end
                        end else begin
                            m_valid_next = 1'b1;
                            drive_next   = drive_of(accum_reg);
                            updated_next = 1'b0;
                            braking_next = 1'b0;
                        end
                    end
                end
            end
            S_TGT1: begin
                if (mul_done) begin
                    mul_ctl.start    = 1'b1;
                    mul_ctl.clear    = 1'b1;
                    mul_ctl.short_op = 1'b1;
                    mul_a            = mul_prod;
                    mul_b            = MUL_BITS'(period_reg);
                    state_next       = S_TGT2;
                end
            end
            S_TGT2: begin
                if (mul_done) begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    state_next = S_ERR;
                end
            end
            S_ERR: begin
                err_next      = err_now;
                mul_ctl.start = 1'b1;
                mul_ctl.clear = 1'b1;
                mul_a         = MUL_W'(ediff);
                mul_b         = kp_reg;
                state_next    = S_PMUL;
            end
            S_PMUL: begin
                if (mul_done) begin
                    // integral product lands on top of the proportional one
                    mul_ctl.start = 1'b1;
                    mul_a         = MUL_W'(err_reg);
                    mul_b         = ki_reg;
                    state_next    = S_IMUL;
                end
            end
            S_IMUL: begin
                if (mul_done) begin
                    accum_next     = ACW'(acc_clamp);
                    last_err_next  = err_reg;
                    pulse_sum_next = '0;
                    ticks_next     = '0;
                    m_valid_next   = 1'b1;
                    drive_next     = drive_of(ACW'(acc_clamp));
                    updated_next   = 1'b1;
                    braking_next   = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_GAIN_PROP:      kp_next = cfg_data;
                REG_GAIN_INTEGRAL:  ki_next = cfg_data;
                REG_TARGET_SPEED: begin
                    speed_next = cfg_data;
                    held_next  = 1'b0;
                end
                REG_COUNTS_PER_REV: ppr_next = cfg_data;
                REG_PERIOD_TICKS:   period_next = cfg_data[7:0];
                REG_DRIVE_LIMIT:    limit_next = cfg_data[14:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            kp_reg        <= '0;
            ki_reg        <= '0;
            speed_reg     <= '0;
            ppr_reg       <= '0;
            period_reg    <= 8'(PERIOD_RESET);
            limit_reg     <= 15'(LIMIT_RESET);
            pulse_sum_reg <= '0;
            ticks_reg     <= '0;
            accum_reg     <= '0;
            last_err_reg  <= '0;
            held_reg      <= 1'b0;
            zero_tgt_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            kp_reg        <= kp_next;
            ki_reg        <= ki_next;
            speed_reg     <= speed_next;
            ppr_reg       <= ppr_next;
            period_reg    <= period_next;
            limit_reg     <= limit_next;
            pulse_sum_reg <= pulse_sum_next;
            ticks_reg     <= ticks_next;
            accum_reg     <= accum_next;
            last_err_reg  <= last_err_next;
            held_reg      <= held_next;
            zero_tgt_reg  <= zero_tgt_next;
            m_valid_reg   <= m_valid_next;
        end
        err_reg     <= err_next;
        drive_reg   <= drive_next;
        updated_reg <= updated_next;
        braking_reg <= braking_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_drive   = drive_reg;
    assign m_updated = updated_reg;
    assign m_braking = braking_reg;

endmodule
`default_nettype wire

@@ tb/tb.sv @@
// testbench for incremental_pi_speed_loop: directed and random items checked against a local loop model
`timescale 1ns / 1ps
module tb;
    import ipsl_pkg::*;

    localparam int FB = FRAC_BITS_DEF;
    localparam logic MODE_TICK  = 1'b0;
    localparam logic MODE_BRAKE = 1'b1;
    localparam longint ERR_MAX = 64'sd2147483647;
    localparam longint ERR_MIN = -ERR_MAX - 1;

    typedef struct {
        logic signed [15:0] drive;
        logic               updated;
        logic               braking;
    } loop_result_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_mode;
    logic signed [10:0]    s_encoder_pulses;
    logic                  m_valid;
    logic                  m_ready;
    logic signed [15:0]    m_drive;
    logic                  m_updated;
    logic                  m_braking;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    incremental_pi_speed_loop #(
        .FRAC_BITS(FB)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_mode(s_mode),
        .s_encoder_pulses(s_encoder_pulses),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_drive(m_drive),
        .m_updated(m_updated),
        .m_braking(m_braking),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // mirror of the loop registers and state
    logic [15:0]        kp_q88;
    logic [15:0]        ki_q88;
    logic signed [15:0] speed_q88;
    logic [15:0]        ppr;
    logic [7:0]         period;
    logic [14:0]        drive_limit;
    int                 pulse_sum;
    int                 ticks;
    longint             drive_accum;
    longint             last_error;
    bit                 target_held_zero;

    loop_result_t expected_drive_results[$];
    int errors;
    bit idle_on;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #4_000_000;
        $display("incremental_pi_speed_loop test failed");
        $finish;
    end

    function automatic longint target_counts();
        longint sp;
        longint mag;
        if (target_held_zero || ppr == 0 || period == 0)
            return 0;
        sp = longint'(speed_q88);
        mag = (sp < 0) ? -sp : sp;
        mag = mag * longint'(ppr) * longint'(period) * (longint'(1) << FB);
        mag = mag / longint'(TARGET_DIV);
        return (sp < 0) ? -mag : mag;
    endfunction

    function automatic loop_result_t step_speed_loop(logic mode, logic signed [10:0] pulses);
        loop_result_t r;
        longint err;
        longint delta;
        longint lim;
        int sum;
        r.drive = '0;
        r.updated = 1'b0;
        r.braking = 1'b0;
        if (mode == MODE_BRAKE) begin
            drive_accum = 0;
            last_error = 0;
            target_held_zero = 1'b1;
            r.braking = 1'b1;
            return r;
        end
        sum = pulse_sum + int'(pulses);
        if (sum > PULSE_SAT)
            sum = PULSE_SAT;
        if (sum < -PULSE_SAT)
            sum = -PULSE_SAT;
        pulse_sum = sum;
        if (ticks < 255)
            ticks++;
        if (ticks >= int'(period)) begin
            err = target_counts() - longint'(pulse_sum) * (longint'(1) << FB);
            if (err > ERR_MAX)
                err = ERR_MAX;
            if (err < ERR_MIN)
                err = ERR_MIN;
            delta = longint'(kp_q88) * (err - last_error) + longint'(ki_q88) * err;
            // arithmetic shift rounds toward minus infinity
            delta = delta >>> GAIN_FRAC;
            drive_accum += delta;
            lim = longint'(drive_limit) << FB;
            if (drive_accum > lim)
                drive_accum = lim;
            if (drive_accum < -lim)
                drive_accum = -lim;
            last_error = err;
            pulse_sum = 0;
            ticks = 0;
            r.updated = 1'b1;
        end
        if (drive_accum >= 0)
            r.drive = 16'(drive_accum >>> FB);
        else
            r.drive = 16'(-((-drive_accum) >>> FB));
        return r;
    endfunction

    // receiver stalls at random while idling is on
    always @(negedge aclk) begin
        m_ready <= !idle_on || ($urandom_range(99) >= 30);
    end

    always @(posedge aclk) begin
        loop_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_drive_results.size() == 0) begin
                $display("%0t: unexpected result: drive %0d updated %0d braking %0d",
                         $time, m_drive, m_updated, m_braking);
                errors++;
            end else begin
                want = expected_drive_results.pop_front();
                if (m_drive !== want.drive) begin
                    $display("%0t: drive mismatch: expected %0d actual %0d",
                             $time, want.drive, m_drive);
                    errors++;
                end
                if (m_updated !== want.updated) begin
                    $display("%0t: updated mismatch: expected %0d actual %0d",
                             $time, want.updated, m_updated);
                    errors++;
                end
                if (m_braking !== want.braking) begin
                    $display("%0t: braking mismatch: expected %0d actual %0d",
                             $time, want.braking, m_braking);
                    errors++;
                end
            end
        end
    end

    task automatic send_item(logic mode, logic signed [10:0] pulses);
        int gap;
        gap = 0;
        while (idle_on && $urandom_range(99) < 30)
            gap++;
        @(negedge aclk);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_mode <= mode;
        s_encoder_pulses <= pulses;
        do @(posedge aclk); while (!s_ready);
        expected_drive_results.push_back(step_speed_loop(mode, pulses));
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_drive_results.size() != 0)
            @(negedge aclk);
    endtask

    // registers change only with nothing in flight
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
        drain_results();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_GAIN_PROP:      kp_q88 = value;
            REG_GAIN_INTEGRAL:  ki_q88 = value;
            REG_TARGET_SPEED: begin
                speed_q88 = value;
                target_held_zero = 1'b0;
            end
            REG_COUNTS_PER_REV: ppr = value;
            REG_PERIOD_TICKS:   period = value[7:0];
            REG_DRIVE_LIMIT:    drive_limit = value[14:0];
            default: ;
        endcase
    endtask

    function automatic logic [15:0] pick_reg_value(logic [CFG_IDX_W-1:0] idx);
        int pick;
        pick = $urandom_range(9);
        case (idx)
            REG_GAIN_PROP, REG_GAIN_INTEGRAL: begin
                if (pick == 0)
                    return 16'd0;
                if (pick == 1)
                    return 16'hFFFF;
                if (pick < 6)
                    return 16'($urandom_range(0, 1023));
                return 16'($urandom_range(0, 65535));
            end
            REG_TARGET_SPEED: begin
                if (pick == 0)
                    return 16'h8000;
                if (pick == 1)
                    return 16'h7FFF;
                return 16'($urandom_range(0, 65535));
            end
            REG_COUNTS_PER_REV: begin
                if (pick == 0)
                    return 16'd0;
                if (pick == 1)
                    return 16'hFFFF;
                return 16'($urandom_range(0, 65535));
            end
            REG_PERIOD_TICKS: begin
                if (pick == 0)
                    return 16'd0;
                if (pick == 1)
                    return 16'd255;
                return 16'($urandom_range(1, 20));
            end
            REG_DRIVE_LIMIT: begin
                if (pick == 0)
                    return 16'd1;
                if (pick == 1)
                    return 16'd32767;
                return 16'($urandom_range(1, 32767));
            end
            default: return 16'd0;
        endcase
    endfunction

    task automatic test_reset_defaults();
        send_item(MODE_TICK, 11'sd1023);
        send_item(MODE_TICK, -11'sd1024);
        send_item(MODE_TICK, 11'sd0);
        send_item(MODE_BRAKE, 11'sd0);
    endtask

    task automatic test_brake_and_hold();
        write_reg(REG_GAIN_PROP, 16'h0100);
        write_reg(REG_GAIN_INTEGRAL, 16'h0040);
        write_reg(REG_COUNTS_PER_REV, 16'd1000);
        write_reg(REG_TARGET_SPEED, 16'h0100);
        // tick counter already past the new period, so the next tick steps
        write_reg(REG_PERIOD_TICKS, 16'd2);
        send_item(MODE_TICK, 11'sd0);
        send_item(MODE_TICK, 11'sd1023);
        send_item(MODE_TICK, -11'sd1024);
        send_item(MODE_BRAKE, 11'sd7);
        send_item(MODE_TICK, 11'sd5);
        send_item(MODE_TICK, 11'sd5);
        // rewriting the target releases the brake hold
        write_reg(REG_TARGET_SPEED, 16'hFE00);
        send_item(MODE_TICK, 11'sd3);
        send_item(MODE_TICK, -11'sd3);
    endtask

    task automatic test_limits_and_period();
        write_reg(REG_PERIOD_TICKS, 16'd0);
        send_item(MODE_TICK, 11'sd1023);
        send_item(MODE_TICK, -11'sd1024);
        write_reg(REG_GAIN_PROP, 16'hFFFF);
        write_reg(REG_GAIN_INTEGRAL, 16'hFFFF);
        write_reg(REG_DRIVE_LIMIT, 16'd1);
        send_item(MODE_TICK, -11'sd1024);
        write_reg(REG_DRIVE_LIMIT, 16'd0);
        send_item(MODE_TICK, 11'sd1023);
        write_reg(REG_TARGET_SPEED, 16'h8000);
        write_reg(REG_COUNTS_PER_REV, 16'hFFFF);
        write_reg(REG_PERIOD_TICKS, 16'd1);
        write_reg(REG_DRIVE_LIMIT, 16'd32767);
        send_item(MODE_TICK, 11'sd0);
        send_item(MODE_TICK, 11'sd0);
        write_reg(REG_TARGET_SPEED, 16'h7FFF);
        send_item(MODE_TICK, 11'sd0);
        write_reg(REG_COUNTS_PER_REV, 16'd0);
        send_item(MODE_TICK, 11'sd0);
    endtask

    task automatic test_random_phases();
        logic signed [10:0] pulses;
        int r;
        for (int phase = 0; phase < 25; phase++) begin
            for (int idx = 0; idx < 6; idx++)
                if ($urandom_range(1) == 1)
                    write_reg(CFG_IDX_W'(idx), pick_reg_value(CFG_IDX_W'(idx)));
            // one long stretch with no idling on either side
            idle_on = (phase != 6);
            for (int n = 0; n < 70; n++) begin
                r = $urandom_range(99);
                pulses = 11'($urandom_range(0, 2047));
                // some phases lean on the pulse extremes to push the sum into saturation
                if (phase % 4 == 1 && $urandom_range(99) < 60)
                    pulses = ($urandom_range(1) == 1) ? 11'sd1023 : -11'sd1024;
                else if (phase % 4 == 2)
                    pulses = 11'($signed($urandom_range(0, 40)) - 20);
                if (r < 5)
                    send_item(MODE_BRAKE, pulses);
                else
                    send_item(MODE_TICK, pulses);
            end
        end
        idle_on = 1'b1;
    endtask

    initial begin
        errors = 0;
        idle_on = 1'b1;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_mode = MODE_TICK;
        s_encoder_pulses = '0;
        m_ready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_GAIN_PROP;
        cfg_data = '0;
        kp_q88 = '0;
        ki_q88 = '0;
        speed_q88 = '0;
        ppr = '0;
        period = 8'(PERIOD_RESET);
        drive_limit = 15'(LIMIT_RESET);
        pulse_sum = 0;
        ticks = 0;
        drive_accum = 0;
        last_error = 0;
        target_held_zero = 1'b0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_brake_and_hold();
        test_limits_and_period();
        test_random_phases();

        drain_results();
        repeat (200) @(posedge aclk);
        if (expected_drive_results.size() != 0)
            errors++;
        if (errors == 0)
            $display("incremental_pi_speed_loop test passed");
        else
            $display("incremental_pi_speed_loop test failed");
        $finish;
    end

endmodule
